>>> design/sui_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sui_pkg: shared types and constants for the dual set store
// Holds the request and result transaction formats, the request and status
// codes, the sequencer state type and the default set depth.
// ----------------------------------------------------------------------------
package sui_pkg;

	localparam int SET_DEPTH = 8;

	typedef enum logic [1:0] {
		REQ_INSERT    = 2'd0,
		REQ_INTERSECT = 2'd1,
		REQ_UNION     = 2'd2,
		REQ_SUBSET    = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		STS_INSERTED  = 3'd0,
		STS_DUPLICATE = 3'd1,
		STS_FULL      = 3'd2,
		STS_MEMBER    = 3'd3,
		STS_EMPTY     = 3'd4,
		STS_SUBSET    = 3'd5
	} status_t;

	typedef struct packed {
		req_t               req_type;
		logic               set_select;
		logic signed [31:0] item_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_value;
		status_t            status;
		logic               is_subset;
		logic               last;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_OUTER,
		S_FETCH,
		S_SRCH
	} state_t;

endpackage
`default_nettype wire

>>> design/sui_obuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sui_obuf: result output register
// Holds one result transaction for the downstream side and takes a new one
// in the cycle the held result leaves.
// ----------------------------------------------------------------------------
module sui_obuf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire sui_pkg::out_item_t push_item,
	output logic                   push_ok,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output sui_pkg::out_item_t     rsp
);

	logic               vld_q;
	sui_pkg::out_item_t item_q;

	assign push_ok   = !vld_q || !rsp_stall;
	assign rsp_valid = vld_q;
	assign rsp       = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (push) begin
			vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			item_q <= push_item;
		end
	end

endmodule
`default_nettype wire

>>> design/sui_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sui_core: set memories and scan sequencer
// Both sets live in synchronous memories with a registered read port.
// The sequencer reads one outer member at a time and scans the other set
// one entry per cycle, comparing against the held key.
// ----------------------------------------------------------------------------
module sui_core #(
	parameter int SET_DEPTH = sui_pkg::SET_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire sui_pkg::in_item_t  req,
	output logic                    push,
	output sui_pkg::out_item_t      push_item,
	input  wire logic               push_ok
);

	localparam int CW = $clog2(SET_DEPTH + 1);
	localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(SET_DEPTH);

	sui_pkg::state_t state_q, state_d;
	sui_pkg::req_t   req_q;

	logic          xb_q;
	logic          phase2_q;
	logic          rv_q;
	logic          sub_q;
	logic          pend_vld_q;
	logic [31:0]   pend_val_q;
	logic [31:0]   key_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] cnt_a_q;
	logic [CW-1:0] cnt_b_q;

	logic [31:0] mem_a [SET_DEPTH];
	logic [31:0] mem_b [SET_DEPTH];
	logic [31:0] rd_a_q;
	logic [31:0] rd_b_q;

	logic [CW-1:0] cx;
	logic [CW-1:0] cy;
	logic [31:0]   rdx;
	logic [31:0]   rdy;
	logic          hit;
	logic          x_read;
	logic          y_read;
	logic          resolve;
	logic          new_mem;
	logic [31:0]   new_val;
	logic          push_req;
	logic          advance;
	logic          wr;
	logic          accept;
	logic          union_p1;
	logic          final_step;
	logic          ren_a;
	logic          ren_b;
	logic [AW-1:0] addr_a;
	logic [AW-1:0] addr_b;

	assign cx       = xb_q ? cnt_b_q : cnt_a_q;
	assign cy       = xb_q ? cnt_a_q : cnt_b_q;
	assign rdx      = xb_q ? rd_b_q : rd_a_q;
	assign rdy      = xb_q ? rd_a_q : rd_b_q;
	assign hit      = rv_q && (rdy == key_q);
	assign union_p1 = (req_q == sui_pkg::REQ_UNION) && !phase2_q;
	assign accept   = req_valid && !req_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sui_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = (req.req_type == sui_pkg::REQ_INSERT) ?
						sui_pkg::S_SRCH : sui_pkg::S_OUTER;
				end
			end
			sui_pkg::S_OUTER: begin
				if (i_q < cx) begin
					state_d = sui_pkg::S_FETCH;
				end else if (!union_p1 && advance) begin
					state_d = sui_pkg::S_IDLE;
				end
			end
			sui_pkg::S_FETCH: begin
				if (!union_p1) begin
					state_d = sui_pkg::S_SRCH;
				end else if (advance) begin
					state_d = sui_pkg::S_OUTER;
				end
			end
			sui_pkg::S_SRCH: begin
				if (resolve && advance) begin
					state_d = (req_q == sui_pkg::REQ_INSERT) ?
						sui_pkg::S_IDLE : sui_pkg::S_OUTER;
				end
			end
			default: state_d = sui_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req_stall  = 1'b1;
		x_read     = 1'b0;
		y_read     = 1'b0;
		resolve    = 1'b0;
		new_mem    = 1'b0;
		new_val    = key_q;
		push_req   = 1'b0;
		push_item  = '0;
		final_step = 1'b0;
		unique case (state_q)
			sui_pkg::S_IDLE: begin
				req_stall = 1'b0;
			end
			sui_pkg::S_OUTER: begin
				if (i_q < cx) begin
					x_read = 1'b1;
				end else if (!union_p1) begin
					final_step         = 1'b1;
					push_req           = 1'b1;
					push_item.last     = 1'b1;
					if (req_q == sui_pkg::REQ_SUBSET) begin
						push_item.status    = sui_pkg::STS_SUBSET;
						push_item.is_subset = sub_q;
					end else if (pend_vld_q) begin
						push_item.status    = sui_pkg::STS_MEMBER;
						push_item.out_value = pend_val_q;
					end else begin
						push_item.status    = sui_pkg::STS_EMPTY;
					end
				end
			end
			sui_pkg::S_FETCH: begin
				if (union_p1) begin
					new_mem = 1'b1;
					new_val = rdx;
				end
			end
			sui_pkg::S_SRCH: begin
				if (hit || (j_q >= cy)) begin
					resolve = 1'b1;
					if (req_q == sui_pkg::REQ_INSERT) begin
						push_req       = 1'b1;
						push_item.last = 1'b1;
						if (hit) begin
							push_item.status = sui_pkg::STS_DUPLICATE;
						end else if (cy >= DEPTH_C) begin
							push_item.status = sui_pkg::STS_FULL;
						end else begin
							push_item.status = sui_pkg::STS_INSERTED;
						end
					end else if (req_q == sui_pkg::REQ_INTERSECT) begin
						new_mem = hit;
					end else if (req_q == sui_pkg::REQ_UNION) begin
						new_mem = !hit;
					end
				end else begin
					y_read = 1'b1;
				end
			end
			default: req_stall = 1'b1;
		endcase
		if (new_mem && pend_vld_q) begin
			push_req            = 1'b1;
			push_item.status    = sui_pkg::STS_MEMBER;
			push_item.out_value = pend_val_q;
			push_item.last      = 1'b0;
		end
	end

	assign advance = !push_req || push_ok;
	assign push    = push_req && push_ok;
	assign wr      = resolve && advance && (req_q == sui_pkg::REQ_INSERT) && !hit &&
		(cy < DEPTH_C);

	assign ren_a  = advance && (xb_q ? y_read : x_read);
	assign ren_b  = advance && (xb_q ? x_read : y_read);
	assign addr_a = xb_q ? j_q[AW-1:0] : i_q[AW-1:0];
	assign addr_b = xb_q ? i_q[AW-1:0] : j_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr && xb_q) begin
			mem_a[cy[AW-1:0]] <= key_q;
		end
		if (ren_a) begin
			rd_a_q <= mem_a[addr_a];
		end
	end

	always_ff @(posedge clk) begin
		if (wr && !xb_q) begin
			mem_b[cy[AW-1:0]] <= key_q;
		end
		if (ren_b) begin
			rd_b_q <= mem_b[addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sui_pkg::S_IDLE;
			req_q      <= sui_pkg::REQ_INSERT;
			xb_q       <= 1'b0;
			phase2_q   <= 1'b0;
			rv_q       <= 1'b0;
			sub_q      <= 1'b1;
			pend_vld_q <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			cnt_a_q    <= '0;
			cnt_b_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				req_q      <= req.req_type;
				xb_q       <= (req.req_type == sui_pkg::REQ_INSERT) ? !req.set_select : 1'b0;
				phase2_q   <= 1'b0;
				sub_q      <= 1'b1;
				pend_vld_q <= 1'b0;
				i_q        <= '0;
				j_q        <= '0;
				rv_q       <= 1'b0;
			end
			if ((state_q == sui_pkg::S_OUTER) && !x_read && union_p1) begin
				xb_q     <= 1'b1;
				phase2_q <= 1'b1;
				i_q      <= '0;
			end
			if ((state_q == sui_pkg::S_FETCH) && !union_p1) begin
				j_q  <= '0;
				rv_q <= 1'b0;
			end
			if (y_read) begin
				j_q  <= j_q + CW'(1);
				rv_q <= 1'b1;
			end
			if (advance && ((resolve && (req_q != sui_pkg::REQ_INSERT)) ||
					((state_q == sui_pkg::S_FETCH) && union_p1))) begin
				i_q <= i_q + CW'(1);
			end
			if (resolve && !hit && (req_q == sui_pkg::REQ_SUBSET)) begin
				sub_q <= 1'b0;
			end
			if (advance && new_mem) begin
				pend_vld_q <= 1'b1;
			end
			if (advance && final_step) begin
				pend_vld_q <= 1'b0;
			end
			if (wr) begin
				if (xb_q) begin
					cnt_a_q <= cnt_a_q + CW'(1);
				end else begin
					cnt_b_q <= cnt_b_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= req.item_value;
		end else if ((state_q == sui_pkg::S_FETCH) && !union_p1) begin
			key_q <= rdx;
		end
		if (advance && new_mem) begin
			pend_val_q <= new_val;
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_a_q <= DEPTH_C) && (cnt_b_q <= DEPTH_C))
		else $error("set count exceeds depth");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> ((state_q == sui_pkg::S_SRCH) && (cy < DEPTH_C)))
		else $error("memory write outside an insert with room");

	a_pend_kind: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> ((req_q == sui_pkg::REQ_INTERSECT) || (req_q == sui_pkg::REQ_UNION)))
		else $error("pending member held for a request that emits none");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != sui_pkg::S_IDLE))
		else $error("sequencer idle right after taking a transaction");
`endif

endmodule
`default_nettype wire

>>> design/dual_set_union_intersection.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_set_union_intersection: two small sets with set queries
// Keeps sets A and B without duplicates and answers insert, intersection,
// union and subset requests with a stream of result transactions.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  sui_pkg::in_item_t
// rsp       out        rsp_valid / rsp_stall  sui_pkg::out_item_t
//
// One request is worked at a time. The time a request takes is set by the
// one-entry-per-cycle scan of the inner set through its memory read port.
// Reset empties both sets at once; the member memories need no clearing.
// A stalled result holds the sequencer only when a further result is due.
// ----------------------------------------------------------------------------
module dual_set_union_intersection #(
	parameter int SET_DEPTH = sui_pkg::SET_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire sui_pkg::in_item_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output sui_pkg::out_item_t     rsp
);

	logic               push;
	logic               push_ok;
	sui_pkg::out_item_t push_item;

	sui_core #(
		.SET_DEPTH(SET_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push      (push),
		.push_item (push_item),
		.push_ok   (push_ok)
	);

	sui_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.push_ok   (push_ok),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire
